FILE: hw/rtl/point_rotation_offset_macros.svh
// Assertion macros for the point rotation offset block.
// Expects clk and rst_n in scope at the place of use; no other dependencies.
`ifndef POINT_ROTATION_OFFSET_MACROS_SVH
`define POINT_ROTATION_OFFSET_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define PRO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define PRO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pro_pkg.sv
// Shared types and constants for the point rotation offset pipeline.
// No dependencies; used by every module of the block.
package pro_pkg;

    // Fixed formats
    localparam int Q_BITS   = 28;
    localparam int XY_W     = 32;
    localparam int OUT_W    = 27;
    localparam int RADIUS_W = 16;
    localparam int RSQ_W    = 2 * RADIUS_W;
    localparam int TURN_IN_W = 16;
    localparam int ANG_W    = 15;
    localparam int MAX_CORDIC_STAGES = 24;

    // One full turn in 1/64 degree
    localparam logic signed [TURN_IN_W:0] TURN = 17'sd23040;

    // Binary angle: theta = (a div 45) * 2^23 + REM_TAB[a mod 45]
    localparam int ANGLE_DIV   = 45;
    localparam int REM_SHIFT   = 23;
    localparam int QA_W        = 9;
    localparam int RA_W        = 6;
    localparam int RECIP_SHIFT = 20;
    localparam logic [ANG_W-1:0] RECIP_DIV = 15'd23302;
    localparam logic [ANG_W-1:0] DIV_CONST = 15'd45;
    localparam longint REM_HALF = 64'sd22;

    // CORDIC start value: inverse gain in Q2.28
    localparam logic signed [XY_W-1:0] INV_GAIN = 32'sd163008218;
    // Residual angle bound after quadrant folding (an eighth turn either way)
    localparam logic signed [XY_W-1:0] RES_LIMIT = 32'sd536870912;

    localparam logic signed [XY_W-1:0] ATAN_TAB [MAX_CORDIC_STAGES] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
    };

    typedef logic [REM_SHIFT-1:0] rem_t;
    typedef rem_t rem_tab_t [2**RA_W];

    // Build the remainder part of the binary angle at elaboration
    function automatic rem_tab_t build_rem_tab();
        rem_tab_t tab;
        for (int i = 0; i < 2**RA_W; i++) begin
            if (i < ANGLE_DIV) begin
                tab[i] = rem_t'(((longint'(i) <<< REM_SHIFT) + REM_HALF) / ANGLE_DIV);
            end else begin
                tab[i] = '0;
            end
        end
        return tab;
    endfunction

    localparam rem_tab_t REM_TAB = build_rem_tab();

    // Quadrant of the rotation angle
    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    // Side information carried alongside the coordinates
    typedef struct packed {
        logic  near;
        quad_t quad;
    } side_t;

endpackage

FILE: hw/rtl/pro_front.sv
// Front end: differences, distance test and angle-to-binary-angle conversion.
// Three register stages; depends on pro_pkg.
module pro_front #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_WIDTH-1:0]         center_x,
    input  logic signed [COORD_WIDTH-1:0]         center_z,
    input  logic signed [COORD_WIDTH-1:0]         point_x,
    input  logic signed [COORD_WIDTH-1:0]         point_z,
    input  logic signed [pro_pkg::TURN_IN_W-1:0]  turn_angle,
    input  logic [pro_pkg::RADIUS_W-1:0]          radius,
    input  logic [pro_pkg::RSQ_W-1:0]             radius_sq,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_WIDTH:0]           out_dx,
    output logic signed [COORD_WIDTH:0]           out_dz,
    output logic signed [pro_pkg::XY_W-1:0]       out_res,
    output pro_pkg::side_t                        out_side
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int BW = ((DW > pro_pkg::RADIUS_W + 1) ? DW : pro_pkg::RADIUS_W + 1) + 1;
    localparam int NSTG = 3;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   rdy;

    // Stage 1 registers
    logic signed [DW-1:0]             dx1_reg, dz1_reg, dx1_next, dz1_next;
    logic                             box1_reg, box1_next;
    logic [pro_pkg::ANG_W-1:0]        ang1_reg, ang1_next;
    // Stage 2 registers
    logic signed [DW-1:0]             dx2_reg, dz2_reg;
    logic                             box2_reg;
    logic [pro_pkg::ANG_W-1:0]        ang2_reg;
    logic [pro_pkg::QA_W-1:0]         qa2_reg, qa2_next;
    logic [pro_pkg::RSQ_W-1:0]        sqx2_reg, sqz2_reg, sqx2_next, sqz2_next;
    // Stage 3 registers
    logic signed [DW-1:0]             dx3_reg, dz3_reg;
    logic signed [pro_pkg::XY_W-1:0]  res3_reg, res3_next;
    pro_pkg::side_t                   side3_reg, side3_next;

    logic signed [BW-1:0]             r_s, dxw, dzw;
    logic signed [pro_pkg::TURN_IN_W:0] a_ext, a_red;
    logic signed [DW-1:0]             ax_full, az_full;
    logic [pro_pkg::RADIUS_W-1:0]     ax16, az16;
    logic [2*pro_pkg::ANG_W-1:0]      qa_prod;
    logic [pro_pkg::ANG_W-1:0]        ra_full;
    logic [pro_pkg::RA_W-1:0]         ra;
    logic [1:0]                       quad_code, top_bits;
    logic [pro_pkg::RSQ_W:0]          sq_sum;

    // Advance a stage when it is empty or its successor takes its transaction
    assign rdy[NSTG] = out_ready;
    assign rdy[NSTG-1:0] = ~valid_reg | rdy[NSTG:1];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            if (rdy[1]) valid_reg[1] <= valid_reg[0];
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // Stage 1: differences, bounding box, angle folded into one turn
    always_comb begin
        dx1_next = DW'(point_x) - DW'(center_x);
        dz1_next = DW'(point_z) - DW'(center_z);
        r_s = BW'(signed'({1'b0, radius}));
        dxw = BW'(dx1_next);
        dzw = BW'(dz1_next);
        box1_next = (dxw > -r_s) && (dxw < r_s) && (dzw > -r_s) && (dzw < r_s);
        a_ext = (pro_pkg::TURN_IN_W + 1)'(turn_angle);
        if (a_ext < 0) begin
            if (a_ext < -pro_pkg::TURN) begin
                a_red = a_ext + pro_pkg::TURN + pro_pkg::TURN;
            end else begin
                a_red = a_ext + pro_pkg::TURN;
            end
        end else if (a_ext >= pro_pkg::TURN) begin
            a_red = a_ext - pro_pkg::TURN;
        end else begin
            a_red = a_ext;
        end
        ang1_next = a_red[pro_pkg::ANG_W-1:0];
    end

    // Stage 2: squares inside the box, quotient of the angle by 45
    always_comb begin
        ax_full = (dx1_reg < 0) ? -dx1_reg : dx1_reg;
        az_full = (dz1_reg < 0) ? -dz1_reg : dz1_reg;
        ax16 = ax_full[pro_pkg::RADIUS_W-1:0];
        az16 = az_full[pro_pkg::RADIUS_W-1:0];
        sqx2_next = pro_pkg::RSQ_W'(ax16) * pro_pkg::RSQ_W'(ax16);
        sqz2_next = pro_pkg::RSQ_W'(az16) * pro_pkg::RSQ_W'(az16);
        qa_prod = (2*pro_pkg::ANG_W)'(ang1_reg) * (2*pro_pkg::ANG_W)'(pro_pkg::RECIP_DIV);
        qa2_next = qa_prod[pro_pkg::RECIP_SHIFT +: pro_pkg::QA_W];
    end

    // Stage 3: exact distance compare, binary angle, quadrant fold
    always_comb begin
        sq_sum = (pro_pkg::RSQ_W + 1)'(sqx2_reg) + (pro_pkg::RSQ_W + 1)'(sqz2_reg);
        side3_next.near = box2_reg && (sq_sum < (pro_pkg::RSQ_W + 1)'(radius_sq));
        ra_full = ang2_reg - pro_pkg::ANG_W'(pro_pkg::ANG_W'(qa2_reg) * pro_pkg::DIV_CONST);
        ra = ra_full[pro_pkg::RA_W-1:0];
        // Round to the nearest quarter turn and keep the residual
        quad_code = qa2_reg[pro_pkg::QA_W-1 -: 2] + {1'b0, qa2_reg[pro_pkg::QA_W-3]};
        top_bits  = qa2_reg[pro_pkg::QA_W-1 -: 2] - quad_code;
        side3_next.quad = pro_pkg::quad_t'(quad_code);
        res3_next = signed'({top_bits, qa2_reg[pro_pkg::QA_W-3:0], pro_pkg::REM_TAB[ra]});
    end

    always_ff @(posedge clk) begin
        if (rdy[0]) begin
            dx1_reg  <= dx1_next;
            dz1_reg  <= dz1_next;
            box1_reg <= box1_next;
            ang1_reg <= ang1_next;
        end
        if (rdy[1]) begin
            dx2_reg  <= dx1_reg;
            dz2_reg  <= dz1_reg;
            box2_reg <= box1_reg;
            ang2_reg <= ang1_reg;
            qa2_reg  <= qa2_next;
            sqx2_reg <= sqx2_next;
            sqz2_reg <= sqz2_next;
        end
        if (rdy[2]) begin
            dx3_reg   <= dx2_reg;
            dz3_reg   <= dz2_reg;
            res3_reg  <= res3_next;
            side3_reg <= side3_next;
        end
    end

    assign out_dx   = dx3_reg;
    assign out_dz   = dz3_reg;
    assign out_res  = res3_reg;
    assign out_side = side3_reg;

endmodule

FILE: hw/rtl/pro_cordic.sv
// CORDIC rotator: one micro-rotation per register stage, yields cos and sin in Q2.28.
// Carries the coordinate differences and side information; depends on pro_pkg.
module pro_cordic #(
    parameter int COORD_WIDTH   = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COORD_WIDTH:0]      in_dx,
    input  logic signed [COORD_WIDTH:0]      in_dz,
    input  logic signed [pro_pkg::XY_W-1:0]  in_res,
    input  pro_pkg::side_t                   in_side,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [COORD_WIDTH:0]      out_dx,
    output logic signed [COORD_WIDTH:0]      out_dz,
    output logic signed [pro_pkg::XY_W-1:0]  out_x,
    output logic signed [pro_pkg::XY_W-1:0]  out_y,
    output pro_pkg::side_t                   out_side
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int N  = CORDIC_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] vsrc;
    logic [N:0]   rdy;

    logic signed [pro_pkg::XY_W-1:0] x_reg [N];
    logic signed [pro_pkg::XY_W-1:0] y_reg [N];
    logic signed [pro_pkg::XY_W-1:0] r_reg [N];
    logic signed [DW-1:0]            dx_reg [N];
    logic signed [DW-1:0]            dz_reg [N];
    pro_pkg::side_t                  side_reg [N];

    logic signed [pro_pkg::XY_W-1:0] x_src [N];
    logic signed [pro_pkg::XY_W-1:0] y_src [N];
    logic signed [pro_pkg::XY_W-1:0] r_src [N];
    logic signed [DW-1:0]            dx_src [N];
    logic signed [DW-1:0]            dz_src [N];
    pro_pkg::side_t                  side_src [N];

    // Advance a stage when it is empty or its successor takes its transaction
    assign rdy[N] = out_ready;
    assign rdy[N-1:0] = ~valid_reg | rdy[N:1];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[N-1];
    assign vsrc = {valid_reg[N-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (rdy[k]) valid_reg[k] <= vsrc[k];
            end
        end
    end

    // Feed the first stage with the inverse gain on the x axis
    assign x_src[0]    = pro_pkg::INV_GAIN;
    assign y_src[0]    = '0;
    assign r_src[0]    = in_res;
    assign dx_src[0]   = in_dx;
    assign dz_src[0]   = in_dz;
    assign side_src[0] = in_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [pro_pkg::XY_W-1:0] xs, ys;
        logic signed [pro_pkg::XY_W-1:0] x_next, y_next, r_next;

        if (k > 0) begin : g_link
            assign x_src[k]    = x_reg[k-1];
            assign y_src[k]    = y_reg[k-1];
            assign r_src[k]    = r_reg[k-1];
            assign dx_src[k]   = dx_reg[k-1];
            assign dz_src[k]   = dz_reg[k-1];
            assign side_src[k] = side_reg[k-1];
        end

        // Rotate toward a zero residual angle
        always_comb begin
            xs = x_src[k] >>> k;
            ys = y_src[k] >>> k;
            if (r_src[k] >= 0) begin
                x_next = x_src[k] - ys;
                y_next = y_src[k] + xs;
                r_next = r_src[k] - pro_pkg::ATAN_TAB[k];
            end else begin
                x_next = x_src[k] + ys;
                y_next = y_src[k] - xs;
                r_next = r_src[k] + pro_pkg::ATAN_TAB[k];
            end
        end

        always_ff @(posedge clk) begin
            if (rdy[k]) begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                r_reg[k]    <= r_next;
                dx_reg[k]   <= dx_src[k];
                dz_reg[k]   <= dz_src[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_x    = x_reg[N-1];
    assign out_y    = y_reg[N-1];
    assign out_dx   = dx_reg[N-1];
    assign out_dz   = dz_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

FILE: hw/rtl/pro_back.sv
// Back end: quadrant unfold, dot products, rounding and the near-center override.
// Four register stages ending in the output register; depends on pro_pkg.
module pro_back #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH:0]          in_dx,
    input  logic signed [COORD_WIDTH:0]          in_dz,
    input  logic signed [pro_pkg::XY_W-1:0]      in_x,
    input  logic signed [pro_pkg::XY_W-1:0]      in_y,
    input  pro_pkg::side_t                       in_side,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pro_pkg::OUT_W-1:0]     offset_x,
    output logic signed [pro_pkg::OUT_W-1:0]     offset_z
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = DW + pro_pkg::XY_W;
    localparam int SW   = PW + 2;
    localparam int RW   = SW - pro_pkg::Q_BITS + 1;
    localparam int NSTG = 4;
    localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (pro_pkg::Q_BITS - 1));

    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   rdy;

    // Stage 1
    logic signed [DW-1:0]             dx1_reg, dz1_reg;
    logic signed [pro_pkg::XY_W-1:0]  c1_reg, s1_reg, c1_next, s1_next;
    logic                             near1_reg;
    // Stage 2
    logic signed [DW-1:0]             dx2_reg, dz2_reg;
    logic signed [PW-1:0]             pxc2_reg, pzs2_reg, pzc2_reg, pxs2_reg;
    logic                             near2_reg;
    // Stage 3
    logic signed [DW-1:0]             dx3_reg, dz3_reg;
    logic signed [SW-1:0]             sx3_reg, sz3_reg, sx3_next, sz3_next;
    logic                             near3_reg;
    // Stage 4 (output)
    logic signed [pro_pkg::OUT_W-1:0] ox_reg, oz_reg, ox_next, oz_next;

    logic signed [RW-1:0]             fin_x, fin_z;

    // Advance a stage when it is empty or its successor takes its transaction
    assign rdy[NSTG] = out_ready;
    assign rdy[NSTG-1:0] = ~valid_reg | rdy[NSTG:1];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            if (rdy[1]) valid_reg[1] <= valid_reg[0];
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
            if (rdy[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    // Stage 1: unfold the quadrant into cos and sin
    always_comb begin
        c1_next = in_x;
        s1_next = in_y;
        case (in_side.quad)
            pro_pkg::QUAD_I:   begin c1_next = in_x;  s1_next = in_y;  end
            pro_pkg::QUAD_II:  begin c1_next = -in_y; s1_next = in_x;  end
            pro_pkg::QUAD_III: begin c1_next = -in_x; s1_next = -in_y; end
            pro_pkg::QUAD_IV:  begin c1_next = in_y;  s1_next = -in_x; end
            default:           begin c1_next = in_x;  s1_next = in_y;  end
        endcase
    end

    // Stage 3: dot products plus rounding bias
    always_comb begin
        sx3_next = SW'(pxc2_reg) + SW'(pzs2_reg) + HALF;
        sz3_next = SW'(pzc2_reg) - SW'(pxs2_reg) + HALF;
    end

    // Stage 4: drop the fraction, subtract the difference, zero near the center
    always_comb begin
        fin_x = RW'(signed'(sx3_reg[SW-1:pro_pkg::Q_BITS])) - RW'(dx3_reg);
        fin_z = RW'(signed'(sz3_reg[SW-1:pro_pkg::Q_BITS])) - RW'(dz3_reg);
        ox_next = near3_reg ? '0 : pro_pkg::OUT_W'(fin_x);
        oz_next = near3_reg ? '0 : pro_pkg::OUT_W'(fin_z);
    end

    always_ff @(posedge clk) begin
        if (rdy[0]) begin
            dx1_reg   <= in_dx;
            dz1_reg   <= in_dz;
            c1_reg    <= c1_next;
            s1_reg    <= s1_next;
            near1_reg <= in_side.near;
        end
        if (rdy[1]) begin
            dx2_reg   <= dx1_reg;
            dz2_reg   <= dz1_reg;
            pxc2_reg  <= PW'(dx1_reg) * PW'(c1_reg);
            pzs2_reg  <= PW'(dz1_reg) * PW'(s1_reg);
            pzc2_reg  <= PW'(dz1_reg) * PW'(c1_reg);
            pxs2_reg  <= PW'(dx1_reg) * PW'(s1_reg);
            near2_reg <= near1_reg;
        end
        if (rdy[2]) begin
            dx3_reg   <= dx2_reg;
            dz3_reg   <= dz2_reg;
            sx3_reg   <= sx3_next;
            sz3_reg   <= sz3_next;
            near3_reg <= near2_reg;
        end
        if (rdy[3]) begin
            ox_reg <= ox_next;
            oz_reg <= oz_next;
        end
    end

    assign offset_x = ox_reg;
    assign offset_z = oz_reg;

endmodule

FILE: hw/rtl/point_rotation_offset.sv
// Top level of the point rotation offset block: configuration register and pipeline.
// Depends on pro_pkg, pro_front, pro_cordic, pro_back and the assertion macros header.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    center_x center_z point_x point_z turn_angle
//  output    out        out_valid / out_stall  offset_x offset_z
//  config    in         cfg_valid / cfg_ready  min_radius
//
// One transaction enters per cycle while in_stall is low; the pipeline has 3 front-end
// stages, one CORDIC stage per micro-rotation and 4 back-end stages.
// Every stage holds its transaction while the next one is full and held; empty stages
// close up, so in_stall rises only when every stage is full and out_stall is high.
// Reset clears all valid bits and sets min_radius to 1; cfg_ready is always high and
// the squared radius is registered from the min_radius register.
`include "point_rotation_offset_macros.svh"

module point_rotation_offset #(
    parameter int COORD_WIDTH   = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [COORD_WIDTH-1:0]        center_x,
    input  logic signed [COORD_WIDTH-1:0]        center_z,
    input  logic signed [COORD_WIDTH-1:0]        point_x,
    input  logic signed [COORD_WIDTH-1:0]        point_z,
    input  logic signed [pro_pkg::TURN_IN_W-1:0] turn_angle,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pro_pkg::OUT_W-1:0]     offset_x,
    output logic signed [pro_pkg::OUT_W-1:0]     offset_z,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pro_pkg::RADIUS_W-1:0]         min_radius
);

    logic [pro_pkg::RADIUS_W-1:0] min_radius_reg;
    logic [pro_pkg::RSQ_W-1:0]    rsq_reg, rsq_next;

    logic                             in_ready;
    logic                             f_valid, f_ready;
    logic signed [COORD_WIDTH:0]      f_dx, f_dz;
    logic signed [pro_pkg::XY_W-1:0]  f_res;
    pro_pkg::side_t                   f_side;
    logic                             c_valid, c_ready;
    logic signed [COORD_WIDTH:0]      c_dx, c_dz;
    logic signed [pro_pkg::XY_W-1:0]  c_x, c_y;
    pro_pkg::side_t                   c_side;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;
    assign rsq_next  = pro_pkg::RSQ_W'(min_radius_reg) * pro_pkg::RSQ_W'(min_radius_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_radius_reg <= pro_pkg::RADIUS_W'(1);
            rsq_reg        <= pro_pkg::RSQ_W'(1);
        end else begin
            if (cfg_valid && cfg_ready) min_radius_reg <= min_radius;
            rsq_reg <= rsq_next;
        end
    end

    assign in_stall = !in_ready;

    pro_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .center_x   (center_x),
        .center_z   (center_z),
        .point_x    (point_x),
        .point_z    (point_z),
        .turn_angle (turn_angle),
        .radius     (min_radius_reg),
        .radius_sq  (rsq_reg),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_dx     (f_dx),
        .out_dz     (f_dz),
        .out_res    (f_res),
        .out_side   (f_side)
    );

    pro_cordic #(
        .COORD_WIDTH   (COORD_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_dx     (f_dx),
        .in_dz     (f_dz),
        .in_res    (f_res),
        .in_side   (f_side),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_dx    (c_dx),
        .out_dz    (c_dz),
        .out_x     (c_x),
        .out_y     (c_y),
        .out_side  (c_side)
    );

    pro_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_dx     (c_dx),
        .in_dz     (c_dz),
        .in_x      (c_x),
        .in_y      (c_y),
        .in_side   (c_side),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .offset_x  (offset_x),
        .offset_z  (offset_z)
    );

    // Backpressure reaches the input only from a held result
    `PRO_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall, "input stalled without a held result")
    // Folded angle must lie within an eighth turn of zero
    `PRO_ASSERT_NOW(a_res_range, f_valid, (f_res >= -pro_pkg::RES_LIMIT) && (f_res <= pro_pkg::RES_LIMIT), "residual angle out of range")
    // Squared radius follows the radius register in the next cycle
    `PRO_ASSERT_NEXT(a_rsq_track, 1'b1, rsq_reg == ($past(min_radius_reg) * $past(min_radius_reg)), "squared radius out of step")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for point_rotation_offset: streams rotation transactions
// through the pipeline and compares every offset with a built-in CORDIC predictor.
// Depends on pro_pkg and the point_rotation_offset RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W      = 24;
    localparam int STAGES       = 16;
    localparam int PIPE_LATENCY = STAGES + 7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TURN_UNITS   = 23040;
    localparam int QUARTER      = 5760;
    localparam int EIGHTH       = 2880;
    localparam longint ROUND_HALF = 64'sd134217728;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [pro_pkg::TURN_IN_W-1:0] turn_t;
    typedef logic [pro_pkg::RADIUS_W-1:0] radius_t;

    typedef struct {
        coord_t cx;
        coord_t cz;
        coord_t px;
        coord_t pz;
        turn_t  ang;
    } rotation_job_t;

    typedef struct {
        logic [pro_pkg::OUT_W-1:0] x;
        logic [pro_pkg::OUT_W-1:0] z;
        logic                      near;
    } offsets_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    coord_t  center_x = '0;
    coord_t  center_z = '0;
    coord_t  point_x = '0;
    coord_t  point_z = '0;
    turn_t   turn_angle = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    logic signed [pro_pkg::OUT_W-1:0] offset_x;
    logic signed [pro_pkg::OUT_W-1:0] offset_z;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    radius_t min_radius = '0;

    rotation_job_t pending_jobs[$];
    offsets_t      expected_offsets[$];
    radius_t       radius_setting = 16'd1;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            error_count = 0;
    int            result_count = 0;
    int            near_count = 0;
    int            setting_count = 1;
    int            cycle_count = 0;

    point_rotation_offset #(
        .COORD_WIDTH   (COORD_W),
        .CORDIC_STAGES (STAGES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .center_x   (center_x),
        .center_z   (center_z),
        .point_x    (point_x),
        .point_z    (point_z),
        .turn_angle (turn_angle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .offset_x   (offset_x),
        .offset_z   (offset_z),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .min_radius (min_radius)
    );

    always #5 clk = ~clk;

    // Compute the offset that turns the point about the center, or zero inside the radius
    function automatic offsets_t rotate_offset(input rotation_job_t job, input radius_t rad);
        longint dx, dz, r, a, res, xr, yr, xs, ys, c, s, ox, oz;
        longint unsigned theta;
        pro_pkg::quad_t quad;
        offsets_t o;
        dx = longint'(job.px) - longint'(job.cx);
        dz = longint'(job.pz) - longint'(job.cz);
        r = longint'(rad);
        o.near = (dx > -r && dx < r && dz > -r && dz < r && dx * dx + dz * dz < r * r);
        if (o.near) begin
            o.x = '0;
            o.z = '0;
            return o;
        end
        // Fold the angle into one turn and scale to a 32-bit binary angle
        a = longint'(job.ang) % TURN_UNITS;
        if (a < 0)
            a += TURN_UNITS;
        theta = ((longint'(a) << 32) + TURN_UNITS / 2) / TURN_UNITS;
        theta &= 64'hFFFF_FFFF;
        quad = pro_pkg::quad_t'(((theta + (64'd1 << 29)) >> 30) & 64'd3);
        res = longint'(theta) - (longint'(quad) << 30);
        if (res >= (64'sd1 <<< 31))
            res -= (64'sd1 <<< 32);
        // Micro-rotations from the gain-corrected start vector
        xr = longint'(pro_pkg::INV_GAIN);
        yr = 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (res >= 0) begin
                xr -= ys;
                yr += xs;
                res -= longint'(pro_pkg::ATAN_TAB[i]);
            end else begin
                xr += ys;
                yr -= xs;
                res += longint'(pro_pkg::ATAN_TAB[i]);
            end
        end
        case (quad)
            pro_pkg::QUAD_I:   begin c = xr;  s = yr;  end
            pro_pkg::QUAD_II:  begin c = -yr; s = xr;  end
            pro_pkg::QUAD_III: begin c = -xr; s = -yr; end
            default:           begin c = yr;  s = -xr; end
        endcase
        ox = ((dx * c + dz * s + ROUND_HALF) >>> pro_pkg::Q_BITS) - dx;
        oz = ((dz * c - dx * s + ROUND_HALF) >>> pro_pkg::Q_BITS) - dz;
        o.x = ox[pro_pkg::OUT_W-1:0];
        o.z = oz[pro_pkg::OUT_W-1:0];
        return o;
    endfunction

    // Driver: hold a stalled transaction, otherwise offer the next job or idle
    always @(posedge clk or negedge rst_n)
    begin
        rotation_job_t job;
        rotation_job_t sent;
        offsets_t pred;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sent.cx = center_x;
                sent.cz = center_z;
                sent.px = point_x;
                sent.pz = point_z;
                sent.ang = turn_angle;
                pred = rotate_offset(sent, radius_setting);
                if (pred.near)
                    near_count++;
                expected_offsets.push_back(pred);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_jobs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    job = pending_jobs.pop_front();
                    center_x   <= job.cx;
                    center_z   <= job.cz;
                    point_x    <= job.px;
                    point_z    <= job.pz;
                    turn_angle <= job.ang;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        offsets_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_offsets.size() == 0)
                begin
                    $error("unexpected result: offset_x %0d, offset_z %0d", offset_x, offset_z);
                    error_count++;
                end
                else
                begin
                    want = expected_offsets.pop_front();
                    if (offset_x !== want.x)
                    begin
                        $error("offset_x: expected %0d, got %0d", $signed(want.x), offset_x);
                        error_count++;
                    end
                    if (offset_z !== want.z)
                    begin
                        $error("offset_z: expected %0d, got %0d", $signed(want.z), offset_z);
                        error_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_job(input coord_t cx, input coord_t cz, input coord_t px,
                           input coord_t pz, input turn_t ang);
        rotation_job_t job;
        job.cx = cx;
        job.cz = cz;
        job.px = px;
        job.pz = pz;
        job.ang = ang;
        pending_jobs.push_back(job);
    endtask

    // Wait until every job has gone in and every result has come out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_jobs.size() != 0 || in_valid || expected_offsets.size() != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_min_radius(input radius_t value);
        @(posedge clk);
        cfg_valid  <= 1'b1;
        min_radius <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_setting = value;
        setting_count++;
    endtask

    // Random jobs: full-range, close to the radius boundary, and medium distances
    task automatic add_random_jobs(input int count);
        coord_t cx, cz, px, pz;
        turn_t ang;
        int span, kind, pick;
        for (int n = 0; n < count; n++)
        begin
            cx = coord_t'($urandom());
            cz = coord_t'($urandom());
            kind = $urandom_range(9);
            span = (kind < 7) ? 2 * int'(radius_setting) + 16 : 65536;
            if (kind < 3)
            begin
                px = coord_t'($urandom());
                pz = coord_t'($urandom());
            end
            else
            begin
                px = coord_t'(longint'(cx) + $urandom_range(2 * span) - span);
                pz = coord_t'(longint'(cz) + $urandom_range(2 * span) - span);
            end
            pick = $urandom_range(9);
            if (pick < 6)
                ang = turn_t'(int'($urandom_range(2 * TURN_UNITS)) - TURN_UNITS);
            else if (pick < 8)
                ang = turn_t'(EIGHTH * (int'($urandom_range(16)) - 8));
            else
                ang = turn_t'($urandom());
            add_job(cx, cz, px, pz, ang);
        end
    endtask

    initial
    begin
        coord_t cmax, cmin;
        cmax = {1'b0, {(COORD_W-1){1'b1}}};
        cmin = {1'b1, {(COORD_W-1){1'b0}}};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed jobs at the reset radius; sender light, receiver heavy
        send_idle_pct = 22;
        recv_stall_pct = 77;
        add_job('0, '0, '0, '0, '0);
        add_job('0, '0, 24'sd256, '0, 16'(QUARTER));
        add_job(cmin, cmin, cmax, cmax, '0);
        add_job(cmax, cmax, cmin, cmin, 16'(2 * QUARTER));
        add_job(cmin, cmax, cmax, cmin, 16'(3 * QUARTER));
        add_job('0, '0, 24'sd1000, -24'sd700, 16'(TURN_UNITS));
        add_job('0, '0, 24'sd1000, -24'sd700, -16'(TURN_UNITS));
        add_job('0, '0, -24'sd5000, 24'sd300, 16'sh7FFF);
        add_job('0, '0, -24'sd5000, 24'sd300, 16'sh8000);
        add_job(24'sd100, 24'sd100, 24'sd90000, 24'sd100, -16'(QUARTER));
        add_job(24'sd100, 24'sd100, 24'sd90000, 24'sd100, 16'sd1);
        add_job(24'sd100, 24'sd100, 24'sd90000, 24'sd100, -16'sd1);
        add_job('0, '0, 24'sd65536, 24'sd65536, 16'(EIGHTH));
        add_job('0, '0, 24'sd65536, 24'sd65536, 16'(3 * EIGHTH));
        add_job('0, '0, 24'sd65536, 24'sd65536, -16'(EIGHTH));
        add_job(24'sd5, 24'sd5, 24'sd6, 24'sd5, 16'(QUARTER));
        add_job(24'sd777, -24'sd4, 24'sd777, -24'sd4, 16'sd1234);
        add_job(cmin, '0, cmax, '0, 16'(QUARTER));
        add_job('0, cmin, '0, cmax, -16'(2 * QUARTER));
        add_job(cmax, cmin, cmax, cmax, 16'sd12345);
        wait_drained();

        // Zero radius: nothing is forced to zero
        write_min_radius(16'd0);
        add_job(24'sd9, 24'sd9, 24'sd9, 24'sd9, 16'(QUARTER));
        add_random_jobs(270);
        wait_drained();

        // Widest radius; sender heavy, receiver light
        send_idle_pct = 77;
        recv_stall_pct = 22;
        write_min_radius(16'hFFFF);
        add_job('0, '0, 24'sd65534, '0, 16'(QUARTER));
        add_job('0, '0, 24'sd65535, '0, 16'(QUARTER));
        add_job('0, '0, -24'sd46340, 24'sd46340, 16'(QUARTER));
        add_random_jobs(270);
        wait_drained();

        // Random radius, no idling on either side
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_min_radius(radius_t'($urandom_range(1, 4000)));
        add_random_jobs(290);
        wait_drained();

        $display("Checked %0d rotation results over %0d minimum radius settings;",
                 result_count, setting_count);
        $display("%0d of them fell inside the radius and were forced to zero.", near_count);
        if (error_count == 0 && expected_offsets.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
